// ----- hdl/tinymt32_generator_unit_macros.svh -----
// assertion macros used by the checker file of the tinymt32 generator
// no dependencies; include by bare file name
`ifndef TINYMT32_GENERATOR_UNIT_MACROS_SVH
`define TINYMT32_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define TMT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tinymt32 check failed");

// next-cycle implication under synchronous active-low reset
`define TMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tinymt32 check failed");

`endif

// ----- hdl/tmt32_pkg.sv -----
// types, constants, microcode table and datapath functions of the tinymt32 generator
// no dependencies
package tmt32_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [3:0][31:0] state_t;

    localparam word_t TMT_MAT1 = 32'h8f70_11ee;
    localparam word_t TMT_MAT2 = 32'hfc78_ff1f;
    localparam word_t TMT_TMAT = 32'h3793_fdff;
    localparam word_t TMT_MASK = 32'h7fff_ffff;
    localparam word_t TMT_MULT = 32'd1812433253;
    localparam int    TMT_SH0  = 1;
    localparam int    TMT_SH1  = 10;
    localparam int    TMT_SH8  = 8;

    // fallback state 'T','I','N','Y' for a seed that lands on the zero orbit
    localparam word_t FIX_W0 = 32'h0000_0054;
    localparam word_t FIX_W1 = 32'h0000_0049;
    localparam word_t FIX_W2 = 32'h0000_004e;
    localparam word_t FIX_W3 = 32'h0000_0059;

    // seven mixing rounds (k = 1..7), then eight warm-up advances
    localparam int MIX_ROUNDS   = 7;
    localparam int WARMUP_STEPS = 8;

    // program layout: wait, mixing rounds, period check, pre-advances
    localparam int STEP_COUNT = 1 + MIX_ROUNDS + 1 + WARMUP_STEPS;
    localparam int STEP_W     = $clog2(STEP_COUNT);

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT      = step_t'(0);
    localparam step_t STEP_MIX_FIRST = step_t'(1);
    localparam step_t STEP_MIX_LAST  = step_t'(MIX_ROUNDS);
    localparam step_t STEP_CHECK     = step_t'(MIX_ROUNDS + 1);
    localparam step_t STEP_ADV_FIRST = step_t'(MIX_ROUNDS + 2);
    localparam step_t STEP_ADV_LAST  = step_t'(STEP_COUNT - 1);

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_MIX,
        OP_CHECK,
        OP_ADV
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  round;
        step_t       next;
    } ucode_t;

    function automatic ucode_t seq_rom(input step_t step);
        ucode_t uc;
        uc.op    = OP_WAIT;
        uc.round = step[2:0];
        uc.next  = step + step_t'(1);
        case (step) inside
            STEP_WAIT: begin
                uc.next = STEP_WAIT;
            end
            [STEP_MIX_FIRST:STEP_MIX_LAST]: begin
                uc.op = OP_MIX;
            end
            STEP_CHECK: begin
                uc.op = OP_CHECK;
            end
            [STEP_ADV_FIRST:STEP_ADV_LAST]: begin
                uc.op = OP_ADV;
                if (step == STEP_ADV_LAST) begin
                    uc.next = STEP_WAIT;
                end
            end
            default: begin
                uc.next = STEP_WAIT;
            end
        endcase
        return uc;
    endfunction

    function automatic state_t tmt_advance(input state_t st);
        word_t  x;
        word_t  y;
        word_t  odd;
        state_t nx;
        x     = (st[0] & TMT_MASK) ^ st[1] ^ st[2];
        y     = st[3];
        x     = x ^ (x << TMT_SH0);
        y     = y ^ (y >> TMT_SH0) ^ x;
        odd   = {32{y[0]}};
        nx[0] = st[1];
        nx[1] = st[2] ^ (odd & TMT_MAT1);
        nx[2] = x ^ (y << TMT_SH1) ^ (odd & TMT_MAT2);
        nx[3] = y;
        return nx;
    endfunction

    function automatic word_t tmt_temper(input state_t st);
        word_t t0;
        word_t t1;
        t1 = st[0] + (st[2] >> TMT_SH8);
        t0 = st[3] ^ t1;
        if (t1[0]) begin
            t0 = t0 ^ TMT_TMAT;
        end
        return t0;
    endfunction

endpackage

// ----- hdl/tinymt32_generator_unit.sv -----
// tinymt32 pseudorandom generator, top level with microcoded seeding sequencer
// depends on tmt32_pkg
//
// channel   dir  ports                        content
// s_        in   s_tvalid s_tready s_tuser    tuser = func (0 seed, 1 draw)
//                s_tdata                      tdata = seed
// m_        out  m_tvalid m_tready m_tdata    tdata = value (draws only)
//
// a draw request: the state advances and the tempered word
// lands in the output register on the accepting edge, so draws stream at one
// per cycle while the output side keeps taking them
// a seed request runs load, seven mixing rounds through the one
// 32x32 multiplier, period check, eight advances; no request is accepted until
// the program returns to the wait step; a seed gives no result
// after reset the state is all zero and every draw returns zero until seeded
// output stalls hold the result register and back-pressure the input
module tinymt32_generator_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // [31:0] seed
    input  logic                 s_tuser,    // [0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output tmt32_pkg::word_t     m_tdata     // [31:0] value
);
    import tmt32_pkg::*;

    // sequencer and datapath registers
    step_t  step_reg,      step_next;
    state_t st_reg,        st_next;
    logic   out_valid_reg, out_valid_next;
    word_t  out_data_reg,  out_data_next;

    ucode_t uc;
    logic   accept;
    state_t adv;
    logic   [1:0] mix_dst;
    logic   [1:0] mix_src;
    word_t  mix_p;
    word_t  mix_f;
    word_t  mix_mul;
    logic   zero_orbit;

    // current control word
    assign uc = seq_rom(step_reg);

    // take a request only at the wait step and when the result slot frees up
    assign s_tready = (uc.op == OP_WAIT) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // shared advance unit, used by draws and by the pre-advance steps
    assign adv = tmt_advance(st_reg);

    // mixing round: word[k mod 4] ^= k + mult * (p ^ (p >> 30)), p = word[(k-1) mod 4]
    assign mix_dst = uc.round[1:0];
    assign mix_src = uc.round[1:0] - 2'd1;
    assign mix_p   = st_reg[mix_src];
    assign mix_f   = mix_p ^ (mix_p >> 30);
    assign mix_mul = mix_f * TMT_MULT;

    // period check looks at the low 31 bits of word 0 and all other words
    assign zero_orbit = ((st_reg[0] & TMT_MASK) == '0) && (st_reg[1] == '0) &&
                        (st_reg[2] == '0) && (st_reg[3] == '0);

    always_comb begin
        step_next      = uc.next;
        st_next        = st_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (uc.op)
            OP_WAIT: begin
                if (accept) begin
                    if (s_tuser) begin
                        // draw: advance and temper in one go
                        st_next        = adv;
                        out_data_next  = tmt_temper(adv);
                        out_valid_next = 1'b1;
                    end else begin
                        // seed: load words and start the program
                        st_next[0] = s_tdata;
                        st_next[1] = TMT_MAT1;
                        st_next[2] = TMT_MAT2;
                        st_next[3] = TMT_TMAT;
                        step_next  = STEP_MIX_FIRST;
                    end
                end
            end
            OP_MIX: begin
                st_next[mix_dst] = st_reg[mix_dst] ^ (mix_mul + word_t'(uc.round));
            end
            OP_CHECK: begin
                if (zero_orbit) begin
                    st_next[0] = FIX_W0;
                    st_next[1] = FIX_W1;
                    st_next[2] = FIX_W2;
                    st_next[3] = FIX_W3;
                end
            end
            OP_ADV: begin
                st_next = adv;
            end
            default: begin
                step_next = STEP_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_WAIT;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

// ----- hdl/tmt32_checker.sv -----
// port-level checks of the tinymt32 generator and the bind that attaches them
// depends on tmt32_pkg and tinymt32_generator_unit_macros.svh
`include "tinymt32_generator_unit_macros.svh"

module tmt32_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  tmt32_pkg::word_t     m_tdata
);
    import tmt32_pkg::*;

    logic  seed_req;
    logic  draw_req;
    logic  out_stall;
    word_t seed_seen;

    assign seed_req  = s_tvalid && s_tready && !s_tuser;
    assign draw_req  = s_tvalid && s_tready && s_tuser;
    assign out_stall = m_tvalid && !m_tready;
    assign seed_seen = s_tdata;

    // stalled result stays and holds its value
    `TMT_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid)
    `TMT_ASSERT_NEXT(a_out_stable, aclk, aresetn, out_stall, $stable(m_tdata))
    // a draw shows its result on the next cycle
    `TMT_ASSERT_NEXT(a_draw_result, aclk, aresetn, draw_req, m_tvalid)
    // a seed request closes the input and, with no result pending, makes none
    `TMT_ASSERT_NEXT(a_seed_busy, aclk, aresetn, seed_req && (seed_seen == seed_seen), !s_tready)
    `TMT_ASSERT_NEXT(a_seed_silent, aclk, aresetn, seed_req && !m_tvalid, !m_tvalid)

endmodule

bind tinymt32_generator_unit tmt32_checker u_tmt32_checker (.*);
